>>> rtl/core/ccet_pkg.sv
`default_nettype none

package ccet_pkg;

	localparam int FRAC_BITS = 56;
	localparam int PIXEL_BITS = 12;
	localparam int ITER_BITS = 16;
	localparam int WORD_BITS = 64;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int ZOOM_BITS = 63;
	localparam int SIZE_BITS = 13;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 64;
	localparam int K_BITS = ((PIXEL_BITS + 1 > SIZE_BITS) ? PIXEL_BITS + 1 : SIZE_BITS) + 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ITERATIONS = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ZOOM_STEP = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_REAL = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_IMAG = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 3'd5;

	localparam logic [ITER_BITS-1:0] MAX_ITER_RESET = ITER_BITS'(256);
	localparam logic [ZOOM_BITS-1:0] ZOOM_RESET = ZOOM_BITS'(64'h0001_0000_0000_0000);
	localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(1024);

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef struct packed {
		logic [ITER_BITS-1:0] max_iterations;
		logic [ZOOM_BITS-1:0] zoom_step;
		word_t offset_real;
		word_t offset_imag;
		logic [SIZE_BITS-1:0] frame_width;
		logic [SIZE_BITS-1:0] frame_height;
	} cfg_t;

	typedef struct packed {
		logic start;
		word_t a;
		word_t b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		prod_t prod;
	} mul_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/cubic_conjugate_escape_time.sv
// Each iteration that does not escape runs six multiplies through the one shared 64x64
// multiplier, which forms its product from four 32x32 partial products in turn.
// Pixels are taken one at a time: pixel_stall stays high until the result word is loaded
// into the output register, and a finished word waits in the output register.
// Reset: arst_n clears the sequencer and output valid and loads the register defaults.
`default_nettype none

module cubic_conjugate_escape_time (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ccet_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [ccet_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input logic pixel_valid,
	output logic pixel_stall,
	input logic [ccet_pkg::PIXEL_BITS-1:0] pixel_column,
	input logic [ccet_pkg::PIXEL_BITS-1:0] pixel_row,
	output logic count_valid,
	input logic count_stall,
	output logic [ccet_pkg::ITER_BITS-1:0] escape_count
);
	import ccet_pkg::*;

	cfg_t cfg;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	ccet_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	ccet_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req),
		.rsp(mul_rsp)
	);

	ccet_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_column(pixel_column),
		.pixel_row(pixel_row),
		.count_valid(count_valid),
		.count_stall(count_stall),
		.escape_count(escape_count),
		.mul_req(mul_req),
		.mul_rsp(mul_rsp)
	);

endmodule

`default_nettype wire

>>> rtl/core/ccet_regs.sv
`default_nettype none

module ccet_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ccet_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [ccet_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output ccet_pkg::cfg_t cfg
);
	import ccet_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_iterations <= MAX_ITER_RESET;
			cfg_q.zoom_step <= ZOOM_RESET;
			cfg_q.offset_real <= '0;
			cfg_q.offset_imag <= '0;
			cfg_q.frame_width <= SIZE_RESET;
			cfg_q.frame_height <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_ITERATIONS: cfg_q.max_iterations <= cfg_data[ITER_BITS-1:0];
				REG_ZOOM_STEP: cfg_q.zoom_step <= cfg_data[ZOOM_BITS-1:0];
				REG_OFFSET_REAL: cfg_q.offset_real <= cfg_data[WORD_BITS-1:0];
				REG_OFFSET_IMAG: cfg_q.offset_imag <= cfg_data[WORD_BITS-1:0];
				REG_FRAME_WIDTH: cfg_q.frame_width <= cfg_data[SIZE_BITS-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[SIZE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ccet_mul.sv
`default_nettype none

module ccet_mul (
	input logic clk,
	input logic arst_n,
	input ccet_pkg::mul_req_t req,
	output ccet_pkg::mul_rsp_t rsp
);
	import ccet_pkg::*;

	localparam int HALF = WORD_BITS / 2;
	localparam logic [2:0] PH_ABS = 3'd0;
	localparam logic [2:0] PH_P0 = 3'd1;
	localparam logic [2:0] PH_SIGN = 3'd5;

	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [2:0] ph_q;
	word_t a_q;
	word_t b_q;
	logic [WORD_BITS-1:0] ua_q;
	logic [WORD_BITS-1:0] ub_q;
	logic [PROD_BITS-1:0] acc_q;
	prod_t prod_q;

	logic [1:0] part;
	logic [HALF-1:0] pa;
	logic [HALF-1:0] pb;
	logic [WORD_BITS-1:0] pp;
	logic [1:0] sh;
	logic [PROD_BITS-1:0] pp_ext;

	function automatic logic [WORD_BITS-1:0] mag(input word_t v);
		logic [WORD_BITS-1:0] r;
		r = v[WORD_BITS-1] ? (WORD_BITS'(0) - $unsigned(v)) : $unsigned(v);
		return r;
	endfunction

	always_comb begin
		part = 2'(ph_q - PH_P0);
		pa = part[1] ? ua_q[WORD_BITS-1:HALF] : ua_q[HALF-1:0];
		pb = part[0] ? ub_q[WORD_BITS-1:HALF] : ub_q[HALF-1:0];
		pp = WORD_BITS'(pa) * WORD_BITS'(pb);
		sh = {1'b0, part[1]} + {1'b0, part[0]};
		pp_ext = PROD_BITS'(pp) << (sh * HALF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q <= 1'b0;
			ph_q <= PH_ABS;
			a_q <= '0;
			b_q <= '0;
			ua_q <= '0;
			ub_q <= '0;
			acc_q <= '0;
			prod_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q <= req.a;
				b_q <= req.b;
				acc_q <= '0;
				busy_q <= 1'b1;
				ph_q <= PH_ABS;
			end else if (busy_q) begin
				if (ph_q == PH_ABS) begin
					ua_q <= mag(a_q);
					ub_q <= mag(b_q);
					neg_q <= a_q[WORD_BITS-1] ^ b_q[WORD_BITS-1];
					ph_q <= PH_P0;
				end else if (ph_q == PH_SIGN) begin
					prod_q <= neg_q ? $signed(PROD_BITS'(0) - acc_q) : $signed(acc_q);
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					acc_q <= acc_q + pp_ext;
					ph_q <= ph_q + 3'd1;
				end
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.prod = prod_q;
	end

endmodule

`default_nettype wire

>>> rtl/core/ccet_seq.sv
`default_nettype none

module ccet_seq (
	input logic clk,
	input logic arst_n,
	input ccet_pkg::cfg_t cfg,
	input logic pixel_valid,
	output logic pixel_stall,
	input logic [ccet_pkg::PIXEL_BITS-1:0] pixel_column,
	input logic [ccet_pkg::PIXEL_BITS-1:0] pixel_row,
	output logic count_valid,
	input logic count_stall,
	output logic [ccet_pkg::ITER_BITS-1:0] escape_count,
	output ccet_pkg::mul_req_t mul_req,
	input ccet_pkg::mul_rsp_t mul_rsp
);
	import ccet_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_FOLD = 3'd3;
	localparam logic [2:0] S_ESC = 3'd4;
	localparam logic [2:0] S_UPD = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	localparam logic [2:0] OP_MAPX = 3'd0;
	localparam logic [2:0] OP_MAPY = 3'd1;
	localparam logic [2:0] OP_R2 = 3'd2;
	localparam logic [2:0] OP_I2 = 3'd3;
	localparam logic [2:0] OP_R3 = 3'd4;
	localparam logic [2:0] OP_I3 = 3'd5;
	localparam logic [2:0] OP_T1 = 3'd6;
	localparam logic [2:0] OP_T2 = 3'd7;

	localparam word_t FOUR = word_t'(64'd4 << FRAC_BITS);

	logic [2:0] state_q;
	logic [2:0] op_q;
	logic count_valid_q;
	logic [ITER_BITS-1:0] escape_count_q;
	logic [ITER_BITS-1:0] res_q;
	logic [ITER_BITS-1:0] n_q;
	logic signed [K_BITS-1:0] kx_q;
	logic signed [K_BITS-1:0] ky_q;
	word_t c_re_q;
	word_t c_im_q;
	word_t z_re_q;
	word_t z_im_q;
	word_t r2_q;
	word_t i2_q;
	word_t r3_q;
	word_t i3_q;
	word_t t1_q;
	word_t opa;
	word_t opb;
	word_t zoom_word;
	word_t prod_fx;
	word_t map_val;

	function automatic word_t sat_sum(input logic [WORD_BITS:0] s);
		word_t r;
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			r = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
		end else begin
			r = s[WORD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic word_t fx_add(input word_t a, input word_t b);
		return sat_sum({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
	endfunction

	function automatic word_t fx_sub(input word_t a, input word_t b);
		return sat_sum({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b});
	endfunction

	function automatic word_t fx_times3(input word_t a);
		logic [WORD_BITS+1:0] s;
		word_t r;
		s = {{2{a[WORD_BITS-1]}}, a} + {a[WORD_BITS-1], a, 1'b0};
		if ((&s[WORD_BITS+1:WORD_BITS-1]) || !(|s[WORD_BITS+1:WORD_BITS-1])) begin
			r = s[WORD_BITS-1:0];
		end else begin
			r = s[WORD_BITS+1] ? WORD_MIN : WORD_MAX;
		end
		return r;
	endfunction

	function automatic word_t sat_wide(input prod_t s);
		word_t r;
		if ((&s[PROD_BITS-1:WORD_BITS-1]) || !(|s[PROD_BITS-1:WORD_BITS-1])) begin
			r = s[WORD_BITS-1:0];
		end else begin
			r = s[PROD_BITS-1] ? WORD_MIN : WORD_MAX;
		end
		return r;
	endfunction

	function automatic word_t map_coord(input prod_t p, input word_t off);
		prod_t s;
		s = (p >>> 1) + prod_t'(off);
		return sat_wide(s);
	endfunction

	assign pixel_stall = (state_q != S_IDLE);
	assign count_valid = count_valid_q;
	assign escape_count = escape_count_q;
	assign zoom_word = {1'b0, cfg.zoom_step};

	always_comb begin
		prod_fx = sat_wide(mul_rsp.prod >>> FRAC_BITS);
		map_val = map_coord(mul_rsp.prod, (op_q == OP_MAPX) ? cfg.offset_real : cfg.offset_imag);
	end

	always_comb begin
		unique case (op_q)
			OP_MAPX: begin
				opa = {{(WORD_BITS-K_BITS){kx_q[K_BITS-1]}}, kx_q};
				opb = zoom_word;
			end
			OP_MAPY: begin
				opa = {{(WORD_BITS-K_BITS){ky_q[K_BITS-1]}}, ky_q};
				opb = zoom_word;
			end
			OP_R2: begin
				opa = z_re_q;
				opb = z_re_q;
			end
			OP_I2: begin
				opa = z_im_q;
				opb = z_im_q;
			end
			OP_R3: begin
				opa = r2_q;
				opb = z_re_q;
			end
			OP_I3: begin
				opa = i2_q;
				opb = z_im_q;
			end
			OP_T1: begin
				opa = fx_times3(r2_q);
				opb = z_im_q;
			end
			OP_T2: begin
				opa = fx_times3(z_re_q);
				opb = i2_q;
			end
		endcase
		mul_req.start = (state_q == S_ISSUE);
		mul_req.a = opa;
		mul_req.b = opb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_MAPX;
			count_valid_q <= 1'b0;
			escape_count_q <= '0;
			res_q <= '0;
			n_q <= '0;
			kx_q <= '0;
			ky_q <= '0;
			c_re_q <= '0;
			c_im_q <= '0;
			z_re_q <= '0;
			z_im_q <= '0;
			r2_q <= '0;
			i2_q <= '0;
			r3_q <= '0;
			i3_q <= '0;
			t1_q <= '0;
		end else begin
			if (count_valid_q && !count_stall && state_q != S_DONE) begin
				count_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pixel_valid) begin
						kx_q <= K_BITS'({pixel_column, 1'b0}) - K_BITS'(cfg.frame_width);
						ky_q <= K_BITS'({pixel_row, 1'b0}) - K_BITS'(cfg.frame_height);
						op_q <= OP_MAPX;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (mul_rsp.done) begin
						unique case (op_q)
							OP_MAPX: begin
								c_re_q <= map_val;
								op_q <= OP_MAPY;
								state_q <= S_ISSUE;
							end
							OP_MAPY: begin
								c_im_q <= map_val;
								z_im_q <= map_val;
								z_re_q <= c_re_q;
								n_q <= '0;
								state_q <= S_FOLD;
							end
							OP_R2: begin
								r2_q <= prod_fx;
								op_q <= OP_I2;
								state_q <= S_ISSUE;
							end
							OP_I2: begin
								i2_q <= prod_fx;
								state_q <= S_ESC;
							end
							OP_R3: begin
								r3_q <= prod_fx;
								op_q <= OP_I3;
								state_q <= S_ISSUE;
							end
							OP_I3: begin
								i3_q <= prod_fx;
								op_q <= OP_T1;
								state_q <= S_ISSUE;
							end
							OP_T1: begin
								t1_q <= prod_fx;
								op_q <= OP_T2;
								state_q <= S_ISSUE;
							end
							OP_T2: begin
								z_im_q <= fx_add(fx_sub(t1_q, i3_q), c_im_q);
								z_re_q <= fx_add(fx_sub(r3_q, prod_fx), c_re_q);
								state_q <= S_UPD;
							end
						endcase
					end
				end
				S_FOLD: begin
					if (n_q < cfg.max_iterations) begin
						z_re_q <= z_re_q[WORD_BITS-1] ? fx_sub('0, z_re_q) : z_re_q;
						z_im_q <= fx_sub('0, z_im_q);
						op_q <= OP_R2;
						state_q <= S_ISSUE;
					end else begin
						res_q <= cfg.max_iterations - ITER_BITS'(1);
						state_q <= S_DONE;
					end
				end
				S_ESC: begin
					if (fx_add(r2_q, i2_q) > FOUR) begin
						res_q <= n_q;
						state_q <= S_DONE;
					end else begin
						op_q <= OP_R3;
						state_q <= S_ISSUE;
					end
				end
				S_UPD: begin
					n_q <= n_q + ITER_BITS'(1);
					state_q <= S_FOLD;
				end
				S_DONE: begin
					if (!count_valid_q || !count_stall) begin
						count_valid_q <= 1'b1;
						escape_count_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ccet_check.sv
`default_nettype none

module ccet_check (
	input logic clk,
	input logic arst_n,
	input logic pixel_valid,
	input logic pixel_stall,
	input logic count_valid,
	input logic count_stall,
	input logic [ccet_pkg::ITER_BITS-1:0] escape_count
);
	import ccet_pkg::*;

	// An accepted pixel keeps the block busy for at least the mapping multiplies.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall |=> pixel_stall ##1 pixel_stall)
		else $error("pixel taken while a pixel was still being worked on");

	// A new result word only appears at the end of work on a pixel.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(count_valid) |-> $past(pixel_stall))
		else $error("result word appeared without a pixel in progress");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		count_valid && count_stall |=> count_valid && $stable(escape_count))
		else $error("stalled result word changed or was dropped");

endmodule

bind cubic_conjugate_escape_time ccet_check u_check (.*);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import ccet_pkg::*;

	localparam int CYCLE_LIMIT = 40_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RECONFIG_EVERY = 35;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LOW = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HIGH = 3'd7;
	localparam word_t ESCAPE_LIMIT = 64'sd4 <<< FRAC_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	logic [PIXEL_BITS-1:0] pixel_column = '0;
	logic [PIXEL_BITS-1:0] pixel_row = '0;
	logic count_valid;
	logic count_stall = 1'b0;
	logic [ITER_BITS-1:0] escape_count;

	cfg_t plane_cfg;
	logic [ITER_BITS-1:0] count_expected[$];
	logic [ITER_BITS-1:0] oldest_count;
	int pixel_idle_pct = 0;
	int count_stall_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;

	cubic_conjugate_escape_time dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_column(pixel_column),
		.pixel_row(pixel_row),
		.count_valid(count_valid),
		.count_stall(count_stall),
		.escape_count(escape_count)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		count_stall <= ($urandom_range(99) < count_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && count_valid && !count_stall) begin
			if (count_expected.size() == 0) begin
				$error("unexpected escape_count word %0d", escape_count);
				mismatches++;
			end else begin
				oldest_count = count_expected.pop_front();
				if (escape_count !== oldest_count) begin
					$error("escape_count mismatch: expected %0d, actual %0d",
						oldest_count, escape_count);
					mismatches++;
				end
			end
		end
	end

	function automatic word_t saturate(input prod_t v);
		if (v > prod_t'(WORD_MAX))
			return WORD_MAX;
		if (v < prod_t'(WORD_MIN))
			return WORD_MIN;
		return word_t'(v);
	endfunction

	function automatic word_t q_mul(input word_t a, input word_t b);
		prod_t p;
		p = prod_t'(a) * prod_t'(b);
		return saturate(p >>> FRAC_BITS);
	endfunction

	function automatic word_t q_add(input word_t a, input word_t b);
		return saturate(prod_t'(a) + prod_t'(b));
	endfunction

	function automatic word_t q_sub(input word_t a, input word_t b);
		return saturate(prod_t'(a) - prod_t'(b));
	endfunction

	function automatic word_t q_triple(input word_t a);
		return saturate(prod_t'(a) * prod_t'(3));
	endfunction

	function automatic word_t plane_coord(input logic [PIXEL_BITS-1:0] idx,
			input logic [SIZE_BITS-1:0] size, input word_t offset);
		prod_t k;
		prod_t span;
		k = prod_t'({idx, 1'b0}) - prod_t'(size);
		span = (k * prod_t'(plane_cfg.zoom_step)) >>> 1;
		return saturate(span + prod_t'(offset));
	endfunction

	function automatic logic [ITER_BITS-1:0] escape_iterations(
			input logic [PIXEL_BITS-1:0] col, input logic [PIXEL_BITS-1:0] row);
		word_t c_re, c_im, z_re, z_im, r2, i2, r3, i3, next_re, next_im;
		logic [ITER_BITS-1:0] count;
		int unsigned n;
		c_re = plane_coord(col, plane_cfg.frame_width, plane_cfg.offset_real);
		c_im = plane_coord(row, plane_cfg.frame_height, plane_cfg.offset_imag);
		z_re = c_re;
		z_im = c_im;
		count = plane_cfg.max_iterations - ITER_BITS'(1);
		for (n = 0; n < plane_cfg.max_iterations; n++) begin
			if (z_re < 0)
				z_re = q_sub(word_t'(0), z_re);
			z_im = q_sub(word_t'(0), z_im);
			r2 = q_mul(z_re, z_re);
			i2 = q_mul(z_im, z_im);
			if (q_add(r2, i2) > ESCAPE_LIMIT)
				return ITER_BITS'(n);
			r3 = q_mul(r2, z_re);
			i3 = q_mul(i2, z_im);
			next_im = q_add(q_sub(q_mul(q_triple(r2), z_im), i3), c_im);
			next_re = q_add(q_sub(r3, q_mul(q_triple(z_re), i2)), c_re);
			z_im = next_im;
			z_re = next_re;
		end
		return count;
	endfunction

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_MAX_ITERATIONS: plane_cfg.max_iterations = value[ITER_BITS-1:0];
			REG_ZOOM_STEP: plane_cfg.zoom_step = value[ZOOM_BITS-1:0];
			REG_OFFSET_REAL: plane_cfg.offset_real = value;
			REG_OFFSET_IMAG: plane_cfg.offset_imag = value;
			REG_FRAME_WIDTH: plane_cfg.frame_width = value[SIZE_BITS-1:0];
			REG_FRAME_HEIGHT: plane_cfg.frame_height = value[SIZE_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_pixel(input logic [PIXEL_BITS-1:0] col,
			input logic [PIXEL_BITS-1:0] row);
		while ($urandom_range(99) < pixel_idle_pct) begin
			pixel_valid = 1'b0;
			@(negedge clk);
		end
		pixel_valid = 1'b1;
		pixel_column = col;
		pixel_row = row;
		do @(posedge clk); while (pixel_stall);
		count_expected.push_back(escape_iterations(col, row));
		@(negedge clk);
		pixel_valid = 1'b0;
	endtask

	task automatic wait_for_counts;
		while (count_expected.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic reprogram_plane;
		logic [63:0] zoom;
		logic [63:0] offset;
		int unsigned iters, w, h;
		iters = ($urandom_range(19) == 0) ? $urandom_range(160, 41) : $urandom_range(40, 1);
		w = $urandom_range(4096, 1);
		h = $urandom_range(4096, 1);
		write_register(REG_MAX_ITERATIONS, {$urandom, 16'($urandom), 16'(iters)});
		zoom = ((64'd1 << 59) / w) * $urandom_range(8, 1) / 8;
		if ($urandom_range(7) == 0)
			zoom = {$urandom, $urandom};
		zoom[63] = $urandom_range(1);
		write_register(REG_ZOOM_STEP, zoom);
		offset = {$urandom, $urandom};
		if ($urandom_range(7) != 0)
			offset = $signed(offset) >>> 6;
		write_register(REG_OFFSET_REAL, offset);
		offset = {$urandom, $urandom};
		if ($urandom_range(7) != 0)
			offset = $signed(offset) >>> 6;
		write_register(REG_OFFSET_IMAG, offset);
		write_register(REG_FRAME_WIDTH, {$urandom, 19'($urandom), 13'(w)});
		write_register(REG_FRAME_HEIGHT, {$urandom, 19'($urandom), 13'(h)});
	endtask

	task automatic test_default_mapping;
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd512, 12'd512);
		wait_for_counts;
	endtask

	task automatic test_iteration_limits;
		write_register(REG_MAX_ITERATIONS, 64'd0);
		send_pixel(12'd512, 12'd512);
		send_pixel(12'd0, 12'd0);
		wait_for_counts;
		write_register(REG_MAX_ITERATIONS, 64'd1);
		send_pixel(12'd512, 12'd512);
		wait_for_counts;
		// Points on the real axis near 2 escape within two iterations, both signs alike.
		write_register(REG_MAX_ITERATIONS, 64'd65535);
		send_pixel(12'd896, 12'd512);
		send_pixel(12'd128, 12'd512);
		send_pixel(12'd1024, 12'd512);
		send_pixel(12'd0, 12'd0);
		wait_for_counts;
	endtask

	task automatic test_mapping_saturation;
		write_register(REG_MAX_ITERATIONS, 64'd8);
		write_register(REG_ZOOM_STEP, 64'h7FFF_FFFF_FFFF_FFFF);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		wait_for_counts;
		write_register(REG_FRAME_WIDTH, 64'd8191);
		write_register(REG_FRAME_HEIGHT, 64'd0);
		send_pixel(12'd4095, 12'd0);
		wait_for_counts;
		write_register(REG_ZOOM_STEP, 64'd0);
		write_register(REG_OFFSET_REAL, 64'h8000_0000_0000_0000);
		write_register(REG_OFFSET_IMAG, 64'h7FFF_FFFF_FFFF_FFFF);
		send_pixel(12'd1, 12'd1);
		wait_for_counts;
		write_register(REG_OFFSET_REAL, 64'd0);
		write_register(REG_OFFSET_IMAG, 64'd0);
		send_pixel(12'd4095, 12'd4095);
		wait_for_counts;
	endtask

	task automatic test_register_decode;
		write_register(REG_MAX_ITERATIONS, 64'hFFFF_FFFF_FFFF_0003);
		write_register(REG_ZOOM_STEP, 64'h8001_0000_0000_0000);
		write_register(REG_OFFSET_REAL, 64'd0);
		write_register(REG_OFFSET_IMAG, 64'd0);
		write_register(REG_FRAME_WIDTH, 64'hFFFF_FFFF_FFFF_E400);
		write_register(REG_FRAME_HEIGHT, 64'h0000_0000_0000_2400);
		write_register(REG_SPARE_LOW, {$urandom, $urandom});
		write_register(REG_SPARE_HIGH, {$urandom, $urandom});
		send_pixel(12'd512, 12'd512);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd896, 12'd512);
		wait_for_counts;
	endtask

	task automatic test_random_pixels(input int items, input int idle_pct, input int stall_pct);
		logic [PIXEL_BITS-1:0] col, row;
		int i;
		pixel_idle_pct = idle_pct;
		count_stall_pct = stall_pct;
		for (i = 0; i < items; i++) begin
			if (i % RECONFIG_EVERY == 0) begin
				wait_for_counts;
				reprogram_plane();
			end
			if ($urandom_range(1))
				col = PIXEL_BITS'($urandom_range(int'(plane_cfg.frame_width) - 1));
			else
				col = PIXEL_BITS'($urandom);
			if ($urandom_range(1))
				row = PIXEL_BITS'($urandom_range(int'(plane_cfg.frame_height) - 1));
			else
				row = PIXEL_BITS'($urandom);
			send_pixel(col, row);
		end
	endtask

	initial begin
		plane_cfg = '{max_iterations: MAX_ITER_RESET, zoom_step: ZOOM_RESET,
			offset_real: '0, offset_imag: '0,
			frame_width: SIZE_RESET, frame_height: SIZE_RESET};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_default_mapping();
		test_iteration_limits();
		test_mapping_saturation();
		test_register_decode();
		test_random_pixels(140, 0, 0);
		test_random_pixels(140, 75, 0);
		test_random_pixels(140, 0, 75);
		test_random_pixels(140, 20, 20);
		wait_for_counts;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
